### src/bds_pkg.sv
`default_nettype none

package bds_pkg;

  // Request codes carried on the input channel.
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_CLEAR      = 3'd4,
    REQ_DUMP_FWD   = 3'd5,
    REQ_DUMP_BWD   = 3'd6
  } req_t;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RESP = 4'b0010,
    S_DRD  = 4'b0100,
    S_DOUT = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // request accepted: perform it now
    logic dump_rd;    // issue the store read for the current dump entry
    logic load_resp;  // load the single result into the output register
    logic load_dump;  // load one dump result and step to the next entry
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump_go;    // the offered request is a dump of a non-empty queue
    logic dump_last;  // the current dump entry is the final one
    logic out_free;   // the output register can take a beat this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

### src/bds_ram.sv
`default_nettype none

module bds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/bds_ctrl.sv
`default_nettype none

module bds_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bds_pkg::dp_stat_t stat,
  output bds_pkg::ctl_cmd_t      cmd
);

  import bds_pkg::*;

  state_t st_r;
  state_t st_nxt;

  // Next state and commands for the datapath.
  always_comb begin
    st_nxt        = st_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          st_nxt    = stat.dump_go ? S_DRD : S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_resp = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      S_DRD: begin
        cmd.dump_rd = 1'b1;
        st_nxt      = S_DOUT;
      end
      S_DOUT: begin
        if (stat.out_free) begin
          cmd.load_dump = 1'b1;
          st_nxt        = stat.dump_last ? S_IDLE : S_DRD;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire

### src/bds_dp.sv
`default_nettype none

module bds_dp #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bds_pkg::ctl_cmd_t  cmd,
  output bds_pkg::dp_stat_t       stat,
  input  wire logic [2:0]         in_req_type,
  input  wire logic signed [31:0] in_push_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_value,
  output logic [6:0]              out_occupancy,
  output logic                    out_is_empty,
  output logic                    out_last
);

  import bds_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_W  = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0]      front_r, front_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      k_r;
  req_t                  req_r;
  logic [1:0]            status_r, status_nxt;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic signed [31:0]    out_value_r;
  logic [6:0]            out_occupancy_r;
  logic                  out_is_empty_r;
  logic                  out_last_r;

  req_t                  req;
  logic                  is_full, is_zero;
  logic [IDX_W-1:0]      cnt_idx, cnt_m1, front_dec, front_inc;
  logic [IDX_W-1:0]      dump_pos, dump_addr;
  logic                  we, re;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [63:0]           push_ext;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [63:0]           rd_ext;
  logic                  pop_ok;

  // Slot of an offset from a base, wrapped at the store depth.
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IDX_W-1:0];
  endfunction

  // Queue conditions and neighbouring slots.
  always_comb begin
    req       = req_t'(in_req_type);
    is_full   = (count_r == DEPTH_C);
    is_zero   = (count_r == '0);
    cnt_idx   = count_r[IDX_W-1:0];
    cnt_m1    = cnt_idx - IDX_W'(1);
    front_dec = (front_r == '0) ? LAST_IDX : front_r - IDX_W'(1);
    front_inc = (front_r == LAST_IDX) ? '0 : front_r + IDX_W'(1);
    dump_pos  = (req_r == REQ_DUMP_FWD) ? k_r : cnt_m1 - k_r;
    dump_addr = wrap_slot(front_r, dump_pos);
  end

  // Word widths between the 32-bit ports and the stored words.
  always_comb begin
    push_ext = {{32{in_push_value[31]}}, in_push_value};
    wdata    = push_ext[DATA_WIDTH-1:0];
    rd_ext   = {64{rdata[DATA_WIDTH-1]}};
    rd_ext[DATA_WIDTH-1:0] = rdata;
  end

  // Request execution: pointer updates and store accesses.
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    we         = 1'b0;
    waddr      = front_dec;
    re         = 1'b0;
    raddr      = dump_addr;
    if (cmd.start) begin
      case (req)
        REQ_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = wrap_slot(front_r, cnt_idx);
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (is_zero) begin
            status_nxt = ST_EMPTY;
          end else begin
            re        = 1'b1;
            raddr     = front_r;
            front_nxt = front_inc;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        REQ_POP_BACK: begin
          if (is_zero) begin
            status_nxt = ST_EMPTY;
          end else begin
            re        = 1'b1;
            raddr     = wrap_slot(front_r, cnt_m1);
            count_nxt = count_r - CNT_W'(1);
          end
        end
        REQ_CLEAR: begin
          front_nxt = '0;
          count_nxt = '0;
        end
        REQ_DUMP_FWD, REQ_DUMP_BWD: begin
          if (is_zero) begin
            status_nxt = ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.dump_rd) begin
      re    = 1'b1;
      raddr = dump_addr;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.dump_go   = ((req == REQ_DUMP_FWD) || (req == REQ_DUMP_BWD)) && !is_zero;
    stat.dump_last = (k_r == cnt_m1);
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign pop_ok = ((req_r == REQ_POP_FRONT) || (req_r == REQ_POP_BACK)) &&
                  (status_r == ST_OK);

  // Element store.
  bds_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Queue pointers and the output beat flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      if (cmd.load_resp || cmd.load_dump) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request context, dump position and the output beat payload.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r    <= req;
      status_r <= status_nxt;
      k_r      <= '0;
    end
    if (cmd.load_resp) begin
      out_status_r    <= status_r;
      out_value_r     <= pop_ok ? rd_ext[31:0] : '0;
      out_occupancy_r <= 7'(count_r);
      out_is_empty_r  <= is_zero;
      out_last_r      <= 1'b1;
    end
    if (cmd.load_dump) begin
      out_status_r    <= ST_OK;
      out_value_r     <= rd_ext[31:0];
      out_occupancy_r <= 7'(count_r);
      out_is_empty_r  <= is_zero;
      out_last_r      <= stat.dump_last;
      k_r             <= k_r + IDX_W'(1);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value     = out_value_r;
  assign out_occupancy = out_occupancy_r;
  assign out_is_empty  = out_is_empty_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  // The occupancy never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("occupancy above depth");

  // The front slot always lies inside the store.
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= LAST_IDX) else $error("front slot outside store");

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_resp || cmd.load_dump) |-> stat.out_free)
    else $error("output beat overwritten");

  // Dump reads only happen while the queue holds entries.
  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_rd |-> !is_zero) else $error("dump read of empty queue");

  // A clear leaves an empty queue with the front at slot zero.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && (req == REQ_CLEAR)) |=> (count_r == '0) && (front_r == '0))
    else $error("clear did not empty the queue");
`endif

endmodule

`default_nettype wire

### src/bounded_deque_store.sv
// Bounded double-ended queue of signed words held in a circular store.
// Input channel (in_valid/in_ready): one request per beat, in_req_type selects
// push front/back, pop front/back, clear, or dump forward/backward, and
// in_push_value carries the word for a push.
// Output channel (out_valid/out_ready): status, popped or dumped word,
// occupancy after the request, empty flag and last marker. Push, pop, clear
// and unused codes give one beat with out_last set; a dump gives one beat per
// entry, the final one marked by out_last, or a single empty-status beat.
// Sequencing: a single-result request passes through the response state,
// where its result is loaded into the output register, before the next
// request is taken. A dump reads each entry through the registered read port
// of the element store and loads it before the next entry is read.
// When the receiver stalls, the result sits in the output register and the
// controller waits; a new request is still accepted while the last beat of the
// previous one waits to be taken.
// Reset empties the queue and points the front at slot zero; the store
// contents are left as they are and are never read before being written.
`default_nettype none

module bounded_deque_store #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_req_type,
  input  wire logic signed [31:0] in_push_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_value,
  output logic [6:0]              out_occupancy,
  output logic                    out_is_empty,
  output logic                    out_last
);

  import bds_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencing of requests and dump entries.
  bds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Pointers, element store and output register.
  bds_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_req_type),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value     (out_value),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
